### hw/rtl/anp_pkg.sv
// ----------------------------------------------------------------------------
// anp_pkg
// Shared types and constants for the ASCII number parser.
// ----------------------------------------------------------------------------
`default_nettype none

package anp_pkg;

  localparam int MAX_RESULT_BITS_DEF = 64;

  // stream widths
  localparam int S_TDATA_W = 8;
  localparam int M_VALUE_W = 64;
  localparam int M_TDATA_W = 72;
  localparam int M_PAD_W   = M_TDATA_W - M_VALUE_W - 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_ENABLE  = 2'd2;

  typedef enum logic [1:0] {
    RADIX_SDEC = 2'd0,
    RADIX_UDEC = 2'd1,
    RADIX_HEX  = 2'd2,
    RADIX_OCT  = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD      = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_LEADING  = 2'd0,
    PH_CONTENT  = 2'd1,
    PH_TRAILING = 2'd2
  } phase_e;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A_LC  = 8'h61;
  localparam logic [7:0] CH_F_LC  = 8'h66;
  localparam logic [7:0] CH_A_UC  = 8'h41;
  localparam logic [7:0] CH_F_UC  = 8'h46;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       is_dec;
    logic       is_oct;
    logic       is_hex;
    logic [3:0] digit;
  } char_class_t;

endpackage

`default_nettype wire

### hw/rtl/anp_char_decode.sv
// ----------------------------------------------------------------------------
// anp_char_decode
// Classifies one input byte: whitespace, sign, digit classes and digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module anp_char_decode
  import anp_pkg::*;
(
  input  wire logic [7:0]  ch_i,
  output char_class_t      cls_o
);

  logic lc_hex;
  logic uc_hex;

  always_comb begin
    lc_hex = (ch_i >= CH_A_LC) && (ch_i <= CH_F_LC);
    uc_hex = (ch_i >= CH_A_UC) && (ch_i <= CH_F_UC);

    cls_o.is_space = (ch_i == CH_SPACE) || (ch_i == CH_LF) || (ch_i == CH_TAB) ||
                     (ch_i == CH_VT) || (ch_i == CH_FF) || (ch_i == CH_CR);
    cls_o.is_plus  = (ch_i == CH_PLUS);
    cls_o.is_minus = (ch_i == CH_MINUS);
    cls_o.is_dec   = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    cls_o.is_oct   = (ch_i >= CH_ZERO) && (ch_i <= CH_SEVEN);
    cls_o.is_hex   = cls_o.is_dec || lc_hex || uc_hex;

    // letters map to 10..15
    priority if (lc_hex) begin
      cls_o.digit = 4'(ch_i - (CH_A_LC - 8'd10));
    end else if (uc_hex) begin
      cls_o.digit = 4'(ch_i - (CH_A_UC - 8'd10));
    end else if (cls_o.is_dec) begin
      cls_o.digit = 4'(ch_i - CH_ZERO);
    end else begin
      cls_o.digit = 4'd0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ascii_number_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_number_parser_unit
// Parses a character stream into an 8/16/32/64-bit integer or an error status.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle unless a last character waits on a full finish
//   record; the accumulator shift-add by ten and overflow compare are combinational.
// Results: the last character passes the input register, the parse stage into
//   the finish record, and the final range check into the output register.
// Reset: parse state cleared, radix signed decimal, 32-bit width, trimming on.
`default_nettype none

module ascii_number_parser_unit
  import anp_pkg::*;
#(
  parameter int MAX_RESULT_BITS = MAX_RESULT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,

  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] ch
  input  wire logic                  s_axis_tuser,   // [0] has_char
  input  wire logic                  s_axis_tlast,

  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [M_TDATA_W-1:0]  m_axis_tdata    // [63:0] value, [65:64] status
);

  localparam int         AW  = MAX_RESULT_BITS;
  localparam int         PW  = AW + 4;
  localparam logic [6:0] AW7 = 7'(MAX_RESULT_BITS);

  // configuration
  radix_e     radix_q;
  logic [1:0] width_q;
  logic       trim_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_ch_q;
  logic       in_has_q;
  logic       in_last_q;

  // parse state
  logic [AW-1:0] acc_q, acc_d;
  phase_e        phase_q, phase_d;
  logic          neg_q, neg_d;
  logic          digit_q, digit_d;
  status_e       err_q, err_d;

  // finish record
  logic          fin_valid_q;
  logic [AW-1:0] fin_acc_q;
  logic          fin_neg_q;
  status_e       fin_pre_q, fin_pre_d;

  // output register
  logic                 m_valid_q;
  logic [M_VALUE_W-1:0] m_value_q, m_value_d;
  status_e              m_status_q, m_status_d;

  // flow control
  logic out_free, fin_adv, fin_free, step_adv, step_fin;

  // datapath
  char_class_t   cls;
  logic [6:0]    w_raw, w_eff;
  logic [AW-1:0] umax, half_m1, lim_step, lim_out;
  logic          radix_pow2, pow2_ovf, pow2_ok;
  logic [AW-1:0] pow2_next;
  logic [PW-1:0] dec_prod;
  logic          dec_ovf;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_SDEC;
      width_q <= 2'd2;
      trim_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RADIX_MODE:   radix_q <= radix_e'(cfg_wdata_i[1:0]);
        CFG_WIDTH_SELECT: width_q <= cfg_wdata_i[1:0];
        CFG_TRIM_ENABLE:  trim_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake chain
  // --------------------------------------------------------------------------
  assign out_free      = !m_valid_q || m_axis_tready;
  assign fin_adv       = fin_valid_q && out_free;
  assign fin_free      = !fin_valid_q || fin_adv;
  assign step_adv      = in_valid_q && (!in_last_q || fin_free);
  assign step_fin      = step_adv && in_last_q;
  assign s_axis_tready = !in_valid_q || step_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q   <= s_axis_tdata[7:0];
      in_has_q  <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Width limits
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (width_q)
      2'd0:    w_raw = 7'd8;
      2'd1:    w_raw = 7'd16;
      2'd2:    w_raw = 7'd32;
      default: w_raw = 7'd64;
    endcase
    w_eff   = (w_raw > AW7) ? AW7 : w_raw;
    umax    = {AW{1'b1}} >> (AW7 - w_eff);
    half_m1 = umax >> 1;
    // signed decimal allows one more on the negative side
    if (radix_q == RADIX_SDEC) begin
      lim_step = neg_q ? half_m1 + AW'(1) : half_m1;
      lim_out  = fin_neg_q ? half_m1 + AW'(1) : half_m1;
    end else begin
      lim_step = umax;
      lim_out  = umax;
    end
  end

  // --------------------------------------------------------------------------
  // Parse stage
  // --------------------------------------------------------------------------
  anp_char_decode u_decode (
    .ch_i  (in_ch_q),
    .cls_o (cls)
  );

  always_comb begin
    radix_pow2 = (radix_q == RADIX_HEX) || (radix_q == RADIX_OCT);
    if (radix_q == RADIX_HEX) begin
      pow2_ovf  = acc_q > (umax >> 4);
      pow2_ok   = cls.is_hex;
      pow2_next = (acc_q << 4) | AW'(cls.digit);
    end else begin
      pow2_ovf  = acc_q > (umax >> 3);
      pow2_ok   = cls.is_oct;
      pow2_next = (acc_q << 3) | AW'(cls.digit);
    end
    // acc * 10 + digit, kept wide so the compare sees every carry
    dec_prod = (PW'(acc_q) << 3) + (PW'(acc_q) << 1) + PW'(cls.digit);
    dec_ovf  = dec_prod > PW'(lim_step);
  end

  always_comb begin
    acc_d   = acc_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    digit_d = digit_q;
    err_d   = err_q;
    if (in_has_q && (err_q == ST_OK)) begin
      if (trim_q && cls.is_space) begin
        if (phase_q != PH_LEADING) phase_d = PH_TRAILING;
      end else if (phase_q == PH_TRAILING) begin
        // inner whitespace is a stray character; range check still first for hex and octal
        err_d = (radix_pow2 && pow2_ovf) ? ST_OVERFLOW : ST_BAD;
      end else if ((phase_q == PH_LEADING) && (radix_q == RADIX_SDEC) &&
                   (cls.is_plus || cls.is_minus)) begin
        neg_d   = cls.is_minus;
        phase_d = PH_CONTENT;
      end else begin
        phase_d = PH_CONTENT;
        if (radix_pow2) begin
          if (pow2_ovf) begin
            err_d = ST_OVERFLOW;
          end else if (!pow2_ok) begin
            err_d = ST_BAD;
          end else begin
            acc_d   = pow2_next;
            digit_d = 1'b1;
          end
        end else begin
          if (!cls.is_dec) begin
            err_d = ST_BAD;
          end else if (dec_ovf) begin
            err_d = ST_OVERFLOW;
          end else begin
            acc_d   = dec_prod[AW-1:0];
            digit_d = 1'b1;
          end
        end
      end
    end

    if (err_d != ST_OK)            fin_pre_d = err_d;
    else if (phase_d == PH_LEADING) fin_pre_d = ST_EMPTY;
    else if (!digit_d)             fin_pre_d = ST_BAD;
    else                           fin_pre_d = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      phase_q <= PH_LEADING;
      neg_q   <= 1'b0;
      digit_q <= 1'b0;
      err_q   <= ST_OK;
    end else if (step_fin) begin
      acc_q   <= '0;
      phase_q <= PH_LEADING;
      neg_q   <= 1'b0;
      digit_q <= 1'b0;
      err_q   <= ST_OK;
    end else if (step_adv) begin
      acc_q   <= acc_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      digit_q <= digit_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (step_fin) begin
      fin_valid_q <= 1'b1;
    end else if (fin_adv) begin
      fin_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fin) begin
      fin_acc_q <= acc_d;
      fin_neg_q <= neg_d;
      fin_pre_q <= fin_pre_d;
    end
  end

  // --------------------------------------------------------------------------
  // Final range check and output register
  // --------------------------------------------------------------------------
  always_comb begin
    if (fin_pre_q != ST_OK)       m_status_d = fin_pre_q;
    else if (fin_acc_q > lim_out) m_status_d = ST_OVERFLOW;
    else                          m_status_d = ST_OK;

    if (m_status_d != ST_OK)  m_value_d = '0;
    else if (fin_neg_q)       m_value_d = M_VALUE_W'(0) - M_VALUE_W'(fin_acc_q);
    else                      m_value_d = M_VALUE_W'(fin_acc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_adv) begin
      m_value_q  <= m_value_d;
      m_status_q <= m_status_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_status_q, m_value_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_status_q != ST_OK)) |-> (m_value_q == '0))
    else $error("error result carries a non-zero value");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fin |=> ((phase_q == PH_LEADING) && (err_q == ST_OK) && !digit_q &&
                  (acc_q == '0)))
    else $error("parse state not cleared after end of string");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((err_q != ST_OK) && !step_fin) |=> (err_q == $past(err_q)))
    else $error("first error overwritten within a string");

  a_fin_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_valid_q && !out_free) |=> (fin_valid_q && $stable(fin_acc_q) &&
                                    $stable(fin_pre_q)))
    else $error("finish record lost under output stall");

endmodule

`default_nettype wire
